FILE: hw/rtl/lcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar cost grid package
// Shared grid geometry, cost limits, register indexes and channel payloads.
// ----------------------------------------------------------------------------
package lcg_pkg;

	// Grid geometry
	localparam int GRID_COLS  = 128;
	localparam int GRID_ROWS  = 128;
	localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
	localparam int COL_W      = $clog2(GRID_COLS);
	localparam int ROW_W      = $clog2(GRID_ROWS);
	localparam int ADDR_W     = $clog2(GRID_CELLS);

	// Field widths
	localparam int COORD_W = 24;
	localparam int IDX_W   = 7;
	localparam int COST_W  = 7;
	localparam int CFG_W   = 24;

	// Cost limits
	localparam logic [COST_W-1:0] COST_MAX = 7'd100;
	localparam logic [COST_W-1:0] COST_MIN = 7'd10;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_PLANAR_MODE     = 3'd0,
		CFG_CORNER_X        = 3'd1,
		CFG_CORNER_Y        = 3'd2,
		CFG_CELLS_PER_METER = 3'd3,
		CFG_NUM_COLS        = 3'd4,
		CFG_NUM_ROWS        = 3'd5,
		CFG_COST_PER_METER  = 3'd6
	} cfg_idx_t;

	// Request command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef struct packed {
		logic                      cmd;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      hit;
		logic [IDX_W-1:0]          read_col;
		logic [IDX_W-1:0]          read_row;
	} lcg_req_t;

	typedef struct packed {
		logic              in_bounds;
		logic [IDX_W-1:0]  cell_col;
		logic [IDX_W-1:0]  cell_row;
		logic [COST_W-1:0] cell_cost;
		logic              updated;
	} lcg_rsp_t;

endpackage

FILE: hw/rtl/lcg_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar cost grid request channel
// Valid/ready channel carrying one point insert or cell read request.
// ----------------------------------------------------------------------------
interface lcg_req_if;
	import lcg_pkg::*;

	logic     valid;
	logic     ready;
	lcg_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/lcg_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar cost grid response channel
// Valid/ready channel carrying one cell result per request.
// ----------------------------------------------------------------------------
interface lcg_rsp_if;
	import lcg_pkg::*;

	logic     valid;
	logic     ready;
	lcg_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/lidar_cost_grid_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar cost grid update
// Maps lidar points to grid cells and raises the stored cell cost; serves
// single cell reads. Cost grid lives in one synchronous single-port-write RAM.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes three pipeline registers (s1, s2, s3)
//   and the output register before its result shows on rsp.
// Throughput: one request per cycle while rsp is not stalled, set by the one
//   grid read-modify-write per cycle; write-back forwards to the next request.
// Reset: arst_n clears control and configuration registers to their reset
//   values, then a clearing pass zeroes all 16384 cells, one per cycle, and
//   req.ready stays low until it ends. Configuration writes are taken always.
// ----------------------------------------------------------------------------
module lidar_cost_grid_update (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_idx,
	input  logic [lcg_pkg::CFG_W-1:0]  cfg_data,
	lcg_req_if.sink                    req,
	lcg_rsp_if.source                  rsp
);
	import lcg_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic                      planar_q;
	logic signed [COORD_W-1:0] corner_x_q;
	logic signed [COORD_W-1:0] corner_y_q;
	logic [23:0]               cpm_q;
	logic [7:0]                num_cols_q;
	logic [7:0]                num_rows_q;
	logic [15:0]               cost_pm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planar_q   <= 1'b0;
			corner_x_q <= '0;
			corner_y_q <= '0;
			cpm_q      <= 24'd43691;
			num_cols_q <= 8'd128;
			num_rows_q <= 8'd128;
			cost_pm_q  <= 16'd17067;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PLANAR_MODE:     planar_q   <= cfg_data[0];
				CFG_CORNER_X:        corner_x_q <= cfg_data[COORD_W-1:0];
				CFG_CORNER_Y:        corner_y_q <= cfg_data[COORD_W-1:0];
				CFG_CELLS_PER_METER: cpm_q      <= cfg_data[23:0];
				CFG_NUM_COLS:        num_cols_q <= cfg_data[7:0];
				CFG_NUM_ROWS:        num_rows_q <= cfg_data[7:0];
				CFG_COST_PER_METER:  cost_pm_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Clearing pass after reset
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(GRID_CELLS - 1)) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Flow control: the whole pipeline advances when the output register
	// is free or being drained. Hold everything otherwise.
	// ------------------------------------------------------------------
	logic adv;
	logic accept;
	logic rsp_valid_q;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = adv && clr_done_q;
	assign accept    = req.valid && req.ready;

	// ------------------------------------------------------------------
	// Stage 1: offset from the grid corner, split into sign and magnitude
	// ------------------------------------------------------------------
	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;

	assign dx = COORD_W'(0) + ($signed({req.data.point_x[COORD_W-1], req.data.point_x})
		- $signed({corner_x_q[COORD_W-1], corner_x_q}));
	assign dy = COORD_W'(0) + ($signed({req.data.point_y[COORD_W-1], req.data.point_y})
		- $signed({corner_y_q[COORD_W-1], corner_y_q}));

	logic                  valid_s1;
	logic                  cmd_s1;
	logic                  hit_s1;
	logic [IDX_W-1:0]      rcol_s1;
	logic [IDX_W-1:0]      rrow_s1;
	logic [COORD_W:0]      magx_s1;
	logic [COORD_W:0]      magy_s1;
	logic                  negx_s1;
	logic                  negy_s1;
	logic [COORD_W-2:0]    zmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= req.data.cmd;
			hit_s1  <= req.data.hit;
			rcol_s1 <= req.data.read_col;
			rrow_s1 <= req.data.read_row;
			negx_s1 <= dx[COORD_W];
			negy_s1 <= dy[COORD_W];
			magx_s1 <= dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
			magy_s1 <= dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
			// Outside planar mode, any height at or below zero costs nothing.
			zmag_s1 <= req.data.point_z[COORD_W-1] ? '0 : req.data.point_z[COORD_W-2:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: scale by cells per metre and by cost per metre
	// ------------------------------------------------------------------
	logic [2*COORD_W:0]   prodx;
	logic [2*COORD_W:0]   prody;
	logic [COORD_W+14:0]  prodz;

	assign prodx = (2*COORD_W+1)'(magx_s1) * (2*COORD_W+1)'(cpm_q);
	assign prody = (2*COORD_W+1)'(magy_s1) * (2*COORD_W+1)'(cpm_q);
	assign prodz = (COORD_W+15)'(zmag_s1) * (COORD_W+15)'(cost_pm_q);

	logic                  valid_s2;
	logic                  cmd_s2;
	logic                  hit_s2;
	logic [IDX_W-1:0]      rcol_s2;
	logic [IDX_W-1:0]      rrow_s2;
	logic [COORD_W:0]      qx_s2;
	logic [COORD_W:0]      qy_s2;
	logic                  negx_s2;
	logic                  negy_s2;
	logic [COORD_W-2:0]    hc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2  <= cmd_s1;
			hit_s2  <= hit_s1;
			rcol_s2 <= rcol_s1;
			rrow_s2 <= rrow_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			qx_s2   <= prodx[2*COORD_W:COORD_W];
			qy_s2   <= prody[2*COORD_W:COORD_W];
			hc_s2   <= prodz[COORD_W+14:16];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 decode: bounds, cell address, saturated new cost.
	// A negative offset smaller than one cell still lands on index zero.
	// ------------------------------------------------------------------
	logic               x_ok;
	logic               y_ok;
	logic               rd_ok;
	logic               ok;
	logic [COL_W-1:0]   col_idx;
	logic [ROW_W-1:0]   row_idx;
	logic [ADDR_W-1:0]  cell_addr;
	logic [COST_W-1:0]  new_cost;
	logic [IDX_W-1:0]   ocol;
	logic [IDX_W-1:0]   orow;

	always_comb begin
		x_ok  = !(negx_s2 && qx_s2 != '0) && (qx_s2 < (COORD_W+1)'(num_cols_q))
			&& (qx_s2 < (COORD_W+1)'(GRID_COLS));
		y_ok  = !(negy_s2 && qy_s2 != '0) && (qy_s2 < (COORD_W+1)'(num_rows_q))
			&& (qy_s2 < (COORD_W+1)'(GRID_ROWS));
		rd_ok = (8'(rcol_s2) < num_cols_q) && (32'(rcol_s2) < 32'(GRID_COLS))
			&& (8'(rrow_s2) < num_rows_q) && (32'(rrow_s2) < 32'(GRID_ROWS));

		if (cmd_s2 == CMD_READ) begin
			ok      = rd_ok;
			col_idx = COL_W'(rcol_s2);
			row_idx = ROW_W'(rrow_s2);
			ocol    = rcol_s2;
			orow    = rrow_s2;
		end else begin
			ok      = hit_s2 && x_ok && y_ok;
			col_idx = qx_s2[COL_W-1:0];
			row_idx = qy_s2[ROW_W-1:0];
			ocol    = ok ? IDX_W'(qx_s2[COL_W-1:0]) : '0;
			orow    = ok ? IDX_W'(qy_s2[ROW_W-1:0]) : '0;
		end

		cell_addr = ADDR_W'(row_idx) * ADDR_W'(GRID_COLS) + ADDR_W'(col_idx);

		if (planar_q) begin
			new_cost = COST_MAX;
		end else if (hc_s2 < (COORD_W-1)'(COST_MIN)) begin
			new_cost = '0;
		end else if (hc_s2 > (COORD_W-1)'(COST_MAX)) begin
			new_cost = COST_MAX;
		end else begin
			new_cost = hc_s2[COST_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: grid read data arrives; compare, write back, form result
	// ------------------------------------------------------------------
	logic                valid_s3;
	logic                cmd_s3;
	logic                ok_s3;
	logic                planar_s3;
	logic [IDX_W-1:0]    col_s3;
	logic [IDX_W-1:0]    row_s3;
	logic [ADDR_W-1:0]   addr_s3;
	logic [COST_W-1:0]   cost_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3    <= cmd_s2;
			ok_s3     <= ok;
			planar_s3 <= planar_q;
			col_s3    <= ocol;
			row_s3    <= orow;
			addr_s3   <= cell_addr;
			cost_s3   <= new_cost;
		end
	end

	// Grid memory: one write port, one registered read port.
	logic [COST_W-1:0] grid_mem [GRID_CELLS];
	logic [COST_W-1:0] rd_data_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [COST_W-1:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rd_data_q <= grid_mem[cell_addr];
		end
	end

	// Forwarding: the read for the item now in stage 3 happened at the same
	// edge as the previous item's write-back, so it saw the old cell value.
	logic              fwd_v_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [COST_W-1:0] fwd_data_q;

	logic              grid_we;
	logic [COST_W-1:0] old_cost;
	logic              raise;
	logic [COST_W-1:0] out_cost;

	always_comb begin
		old_cost = (fwd_v_q && fwd_addr_q == addr_s3) ? fwd_data_q : rd_data_q;
		raise    = cost_s3 > old_cost;
		grid_we  = valid_s3 && adv && ok_s3 && (cmd_s3 == CMD_INSERT)
			&& (planar_s3 || raise);

		if (!ok_s3) begin
			out_cost = '0;
		end else if (cmd_s3 == CMD_INSERT && (planar_s3 || raise)) begin
			out_cost = cost_s3;
		end else begin
			out_cost = old_cost;
		end

		// Clearing pass owns the write port until it finishes.
		if (!clr_done_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = grid_we;
			mem_waddr = addr_s3;
			mem_wdata = cost_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (adv) begin
			fwd_v_q <= grid_we;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q <= addr_s3;
			fwd_data_q <= cost_s3;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	lcg_rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.in_bounds <= ok_s3;
			rsp_q.cell_col  <= col_s3;
			rsp_q.cell_row  <= row_s3;
			rsp_q.cell_cost <= out_cost;
			rsp_q.updated   <= ok_s3 && (cmd_s3 == CMD_INSERT) && raise;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done_q |-> !req.ready)
		else $error("request accepted during grid clearing pass");

	a_cost_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> mem_wdata <= COST_MAX)
		else $error("grid write above cost ceiling");

	a_update_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.updated |-> rsp.data.in_bounds && rsp.data.cell_cost != '0)
		else $error("update reported for an out-of-bounds or zero-cost cell");

	a_write_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && clr_done_q |-> valid_s3 && ok_s3)
		else $error("grid write without a valid in-bounds item");

endmodule

FILE: sim/tb_lidar_cost_grid_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar cost grid update testbench
// Streams point inserts and cell reads through the request channel under
// several grid settings. A shadow cost grid predicts every response, and
// the responses are checked field by field and in order.
// ----------------------------------------------------------------------------
module tb_lidar_cost_grid_update;
	import lcg_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 6;
	// Bound for the clearing pass over all 16384 cells plus ~770 requests,
	// with their gaps and stalls.
	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES  = 12;
	localparam int MAX_PRINTS   = 100;
	localparam int RECENT_DEPTH = 8;
	localparam int NUM_PLANS    = 7;

	// Response-side stall patterns
	typedef enum int {SINK_OPEN, SINK_COIN, SINK_LIGHT, SINK_PERIODIC} sink_mode_t;

	// One complete set of grid settings
	typedef struct {
		logic                      planar;
		logic signed [COORD_W-1:0] corner_x;
		logic signed [COORD_W-1:0] corner_y;
		logic [CFG_W-1:0]          cells_pm;
		logic [7:0]                cols;
		logic [7:0]                rows;
		logic [15:0]               cost_pm;
	} grid_cfg_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [2:0]       cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	lcg_req_if req_ch();
	lcg_rsp_if rsp_ch();

	lidar_cost_grid_update dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// Shadow of the block: settings in force and the cost of every cell
	grid_cfg_t         cfg;
	logic [COST_W-1:0] shadow_grid [GRID_CELLS];

	lcg_req_t request_q[$];      // requests waiting to be driven
	lcg_rsp_t cell_expect_q[$];  // predicted responses, oldest first
	int       recent_cells[$];   // cells hit lately, row * GRID_COLS + col

	int mismatch_count = 0;
	int cycle_count    = 0;

	grid_cfg_t plan_cfg [1:NUM_PLANS];
	int        plan_items [1:NUM_PLANS];

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	function automatic int active_cols();
		return (cfg.cols < GRID_COLS) ? int'(cfg.cols) : GRID_COLS;
	endfunction

	function automatic int active_rows();
		return (cfg.rows < GRID_ROWS) ? int'(cfg.rows) : GRID_ROWS;
	endfunction

	// Map one coordinate onto a cell index, truncating toward zero. A point
	// less than one cell below the corner still lands on index 0.
	function automatic bit locate(input logic signed [COORD_W-1:0] p,
			input logic signed [COORD_W-1:0] corner, input int lim, output int idx);
		longint d, mag, q;
		d   = longint'(p) - longint'(corner);
		mag = (d < 0) ? -d : d;
		q   = (mag * longint'(cfg.cells_pm)) >>> 24;
		idx = 0;
		if (d < 0 && q != 0)
			return 1'b0;
		if (d < 0)
			q = 0;
		if (q >= lim)
			return 1'b0;
		idx = int'(q);
		return 1'b1;
	endfunction

	// Height cost: small costs snap to zero, large ones clamp to the max
	function automatic int height_cost(logic signed [COORD_W-1:0] z);
		longint zz, c;
		zz = longint'(z);
		if (zz <= 0)
			return 0;
		c = (zz * longint'(cfg.cost_pm)) >>> 16;
		if (c < COST_MIN)
			return 0;
		if (c > COST_MAX)
			return int'(COST_MAX);
		return int'(c);
	endfunction

	// Apply one accepted request to the shadow grid and return its response
	function automatic lcg_rsp_t update_shadow_grid(lcg_req_t r);
		lcg_rsp_t          o;
		int                c, rw, at;
		logic [COST_W-1:0] old_cost, new_cost;
		o = '0;
		if (r.cmd == CMD_READ) begin
			// Echo the cell even when it lies outside the active grid
			o.cell_col = r.read_col;
			o.cell_row = r.read_row;
			if (r.read_col < active_cols() && r.read_row < active_rows()) begin
				o.in_bounds = 1'b1;
				o.cell_cost = shadow_grid[r.read_row * GRID_COLS + r.read_col];
			end
		end else if (r.hit) begin
			if (locate(r.point_x, cfg.corner_x, active_cols(), c) &&
					locate(r.point_y, cfg.corner_y, active_rows(), rw)) begin
				at       = rw * GRID_COLS + c;
				old_cost = shadow_grid[at];
				new_cost = cfg.planar ? COST_MAX : COST_W'(height_cost(r.point_z));
				// Costs only ever rise
				if (new_cost > old_cost) begin
					shadow_grid[at] = new_cost;
					o.updated       = 1'b1;
				end
				o.in_bounds = 1'b1;
				o.cell_col  = IDX_W'(c);
				o.cell_row  = IDX_W'(rw);
				o.cell_cost = shadow_grid[at];
			end
		end
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------------

	function automatic lcg_req_t noise_item();
		lcg_req_t r;
		r.cmd      = 1'($urandom_range(0, 1));
		r.point_x  = COORD_W'($urandom);
		r.point_y  = COORD_W'($urandom);
		r.point_z  = COORD_W'($urandom);
		r.hit      = 1'($urandom_range(0, 1));
		r.read_col = IDX_W'($urandom);
		r.read_row = IDX_W'($urandom);
		return r;
	endfunction

	function automatic lcg_req_t mk_insert(logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z, logic hit);
		lcg_req_t r;
		r         = noise_item();
		r.cmd     = CMD_INSERT;
		r.point_x = x;
		r.point_y = y;
		r.point_z = z;
		r.hit     = hit;
		return r;
	endfunction

	function automatic lcg_req_t mk_read(int col, int row);
		lcg_req_t r;
		r          = noise_item();
		r.cmd      = CMD_READ;
		r.read_col = IDX_W'(col);
		r.read_row = IDX_W'(row);
		return r;
	endfunction

	// Append one request to the pending queue
	function automatic void add_request(lcg_req_t r);
		request_q.insert(request_q.size(), r);
	endfunction

	// Width of one cell in coordinate units under the current setting
	function automatic longint cell_span();
		longint s;
		s = (cfg.cells_pm != 0) ? ((longint'(1) << 24) / longint'(cfg.cells_pm)) : 256;
		return (s < 1) ? 1 : s;
	endfunction

	// A coordinate somewhere inside cell idx along one axis (may wrap)
	function automatic logic signed [COORD_W-1:0] axis_coord(
			logic signed [COORD_W-1:0] corner, int idx);
		longint base;
		if (cfg.cells_pm == 0)
			return COORD_W'(corner + longint'($urandom_range(0, 255)));
		base = ((longint'(idx) << 24) + longint'(cfg.cells_pm) - 1) /
			longint'(cfg.cells_pm);
		return COORD_W'(corner + base + ($urandom % cell_span()));
	endfunction

	// Just below the corner, just past the last cell, or in the last cell
	function automatic logic signed [COORD_W-1:0] edge_coord(
			logic signed [COORD_W-1:0] corner, int lim);
		case ($urandom_range(0, 2))
			0: return COORD_W'(corner
				- longint'($urandom_range(1, int'(2 * cell_span() + 1))));
			1: return axis_coord(corner, lim);
			default: return axis_coord(corner, (lim > 0) ? lim - 1 : 0);
		endcase
	endfunction

	// Heights mostly around the interesting cost band
	function automatic logic signed [COORD_W-1:0] pick_height();
		longint band;
		int     k;
		k    = $urandom_range(0, 99);
		band = (cfg.cost_pm != 0) ? ((longint'(101) << 16) / longint'(cfg.cost_pm) + 1)
			: 1000;
		if (band > 8388607)
			band = 8388607;
		if (k < 70)
			return COORD_W'($urandom_range(0, int'(band + band / 4)));
		else if (k < 85)
			return COORD_W'(-longint'($urandom_range(0, 8388608)));
		return COORD_W'($urandom);
	endfunction

	function automatic void remember_cell(int col, int row);
		recent_cells.insert(recent_cells.size(), row * GRID_COLS + col);
		if (recent_cells.size() > RECENT_DEPTH)
			void'(recent_cells.pop_front());
	endfunction

	function automatic lcg_req_t rand_item();
		lcg_req_t r;
		int       k, col, row, slot, lim_c, lim_r;
		r     = noise_item();
		k     = $urandom_range(0, 99);
		lim_c = (active_cols() > 0) ? active_cols() : 1;
		lim_r = (active_rows() > 0) ? active_rows() : 1;
		if (k < 55) begin
			// Well-formed hit, often on a cell touched lately
			if (recent_cells.size() > 0 && $urandom_range(0, 99) < 30) begin
				slot = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
				col  = slot % GRID_COLS;
				row  = slot / GRID_COLS;
			end else begin
				col = $urandom_range(0, lim_c - 1);
				row = $urandom_range(0, lim_r - 1);
			end
			remember_cell(col, row);
			r = mk_insert(axis_coord(cfg.corner_x, col), axis_coord(cfg.corner_y, row),
				pick_height(), 1'b1);
		end else if (k < 65) begin
			// Hit that often lies near the grid border on one or both axes
			r = mk_insert(axis_coord(cfg.corner_x, $urandom_range(0, lim_c - 1)),
				axis_coord(cfg.corner_y, $urandom_range(0, lim_r - 1)), pick_height(), 1'b1);
			if ($urandom_range(0, 2) != 0)
				r.point_x = edge_coord(cfg.corner_x, active_cols());
			if ($urandom_range(0, 2) != 1)
				r.point_y = edge_coord(cfg.corner_y, active_rows());
		end else if (k < 70) begin
			r.cmd = CMD_INSERT;
			r.hit = 1'b0;
		end else if (k < 90) begin
			if (recent_cells.size() > 0 && $urandom_range(0, 99) < 60) begin
				slot = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
				r    = mk_read(slot % GRID_COLS, slot / GRID_COLS);
			end else
				r = mk_read($urandom_range(0, 127), $urandom_range(0, 127));
		end
		return r;
	endfunction

	// Hand-picked requests under the reset settings: one cell is 384 units
	// (1.5 m), the cost band runs from height 39 to 387.
	task automatic queue_directed();
		add_request(mk_read(0, 0));
		add_request(mk_insert(0, 0, 0, 1'b1));          // zero height
		add_request(mk_insert(0, 0, 38, 1'b1));         // cost 9 snaps to 0
		add_request(mk_insert(0, 0, 39, 1'b1));         // lowest kept cost
		add_request(mk_insert(0, 0, 387, 1'b1));        // cost 100, exactly the cap
		add_request(mk_insert(0, 0, 388, 1'b1));        // clamps, no raise
		add_request(mk_insert(0, 0, 200, 1'b1));        // lower cost, no raise
		add_request(mk_insert(400, 0, 8388607, 1'b1));  // tallest point
		add_request(mk_insert(800, 400, -8388608, 1'b1));
		add_request(mk_insert(1000, 1000, 300, 1'b0));  // no return
		add_request(mk_insert(-1, -1, 200, 1'b1));      // sliver below corner
		add_request(mk_insert(-384, 0, 200, 1'b1));     // a full cell below
		add_request(mk_insert(48768, 48768, 200, 1'b1)); // top corner cell
		add_request(mk_insert(49152, 0, 200, 1'b1));    // one past the last column
		add_request(mk_insert(0, 49152, 200, 1'b1));    // one past the last row
		add_request(mk_insert(8388607, -8388608, 200, 1'b1));
		add_request(mk_insert(-8388608, 8388607, 200, 1'b1));
		add_request(mk_read(127, 127));
		add_request(mk_read(1, 0));
		add_request(mk_read(127, 0));
		add_request(mk_read(0, 127));
		add_request(mk_insert(48768, 48768, 387, 1'b1)); // raise a stored cost
		add_request(mk_read(127, 127));
	endtask

	// ------------------------------------------------------------------------
	// Configuration and sequencing
	// ------------------------------------------------------------------------

	// Write every register back to back, then drop the enable
	task automatic apply_settings(grid_cfg_t s);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_PLANAR_MODE;
		cfg_data <= CFG_W'(s.planar);
		@(posedge clk);
		cfg_idx  <= CFG_CORNER_X;
		cfg_data <= s.corner_x;
		@(posedge clk);
		cfg_idx  <= CFG_CORNER_Y;
		cfg_data <= s.corner_y;
		@(posedge clk);
		cfg_idx  <= CFG_CELLS_PER_METER;
		cfg_data <= s.cells_pm;
		@(posedge clk);
		cfg_idx  <= CFG_NUM_COLS;
		cfg_data <= CFG_W'(s.cols);
		@(posedge clk);
		cfg_idx  <= CFG_NUM_ROWS;
		cfg_data <= CFG_W'(s.rows);
		@(posedge clk);
		cfg_idx  <= CFG_COST_PER_METER;
		cfg_data <= CFG_W'(s.cost_pm);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cfg = s;
	endtask

	// Sample at the falling edge so the check never races the drivers
	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_q.size() != 0 || req_ch.valid || cell_expect_q.size() != 0);
	endtask

	task automatic report(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	initial begin
		// Settings per phase: planar, corner x, corner y, cells per metre,
		// columns, rows, cost per metre. Most extremes sit in phases 2 to 4.
		plan_cfg[1] = '{1'b0, -2560, -1280, 24'd262144, 8'd100, 8'd64, 16'd17067};
		plan_cfg[2] = '{1'b1, 8388607, -8388608, 24'd16777215, 8'd255, 8'd128, 16'd65535};
		plan_cfg[3] = '{1'b0, -8388608, 0, 24'd0, 8'd1, 8'd1, 16'd0};
		plan_cfg[4] = '{1'b0, 0, 0, 24'd65536, 8'd0, 8'd5, 16'd256};
		plan_cfg[5] = '{1'b0, -1280, -1280, 24'd65536, 8'd128, 8'd128, 16'd65535};
		plan_cfg[6] = '{1'b1, 512, -512, 24'd131072, 8'd2, 8'd3, 16'd17067};
		plan_cfg[7] = '{1'b0, -25600, 12800, 24'd43691, 8'd37, 8'd255, 16'd1};
		plan_items  = '{150, 60, 60, 30, 250, 80, 120};

		// Hold every input known from time zero
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = CFG_PLANAR_MODE;
		cfg_data     = '0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;

		cfg = '{1'b0, 0, 0, 24'd43691, 8'd128, 8'd128, 16'd17067};
		foreach (shadow_grid[i])
			shadow_grid[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings first; requests wait out the clearing pass on ready
		queue_directed();
		wait_drained();

		// Grid contents carry across setting changes
		for (int p = 1; p <= NUM_PLANS; p++) begin
			apply_settings(plan_cfg[p]);
			repeat (plan_items[p]) add_request(rand_item());
			wait_drained();
		end

		// Let any stray response surface before calling it
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Request driver: bursts of random length with random gaps between them
	// ------------------------------------------------------------------------

	int burst_left = 1;
	int gap_left   = 0;

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40)
			return 0;
		else if (k < 80)
			return $urandom_range(1, 4);
		else if (k < 95)
			return $urandom_range(5, 12);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin : request_driver
		// Predict at acceptance, so the shadow grid sees requests in order
		if (req_ch.valid && req_ch.ready)
			cell_expect_q.insert(cell_expect_q.size(), update_shadow_grid(req_ch.data));
		// Hold a request that has not been taken yet
		if (!req_ch.valid || req_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (request_q.size() > 0) begin
				req_ch.valid <= 1'b1;
				req_ch.data  <= request_q.pop_front();
				if (burst_left > 1)
					burst_left--;
				else begin
					burst_left = $urandom_range(1, 40);
					gap_left   = pick_gap();
				end
			end else
				req_ch.valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Response monitor: check in order, stall on a pattern of its own
	// ------------------------------------------------------------------------

	sink_mode_t sink_mode = SINK_OPEN;
	int         mode_left = 0;
	int         period    = 2;
	int         tick      = 0;

	always @(posedge clk) begin : response_monitor
		lcg_rsp_t want;
		logic     take;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (cell_expect_q.size() == 0)
				report($sformatf("response with nothing outstanding: %p", rsp_ch.data));
			else begin
				want = cell_expect_q.pop_front();
				if (rsp_ch.data.in_bounds !== want.in_bounds)
					report($sformatf("in_bounds got %b want %b",
						rsp_ch.data.in_bounds, want.in_bounds));
				if (rsp_ch.data.cell_col !== want.cell_col)
					report($sformatf("cell_col got %0d want %0d",
						rsp_ch.data.cell_col, want.cell_col));
				if (rsp_ch.data.cell_row !== want.cell_row)
					report($sformatf("cell_row got %0d want %0d",
						rsp_ch.data.cell_row, want.cell_row));
				if (rsp_ch.data.cell_cost !== want.cell_cost)
					report($sformatf("cell_cost got %0d want %0d at col %0d row %0d",
						rsp_ch.data.cell_cost, want.cell_cost, want.cell_col, want.cell_row));
				if (rsp_ch.data.updated !== want.updated)
					report($sformatf("updated got %b want %b at col %0d row %0d",
						rsp_ch.data.updated, want.updated, want.cell_col, want.cell_row));
			end
		end

		// Switch stall pattern every so often
		if (mode_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 120);
			period    = $urandom_range(2, 5);
		end else
			mode_left--;
		tick++;
		case (sink_mode)
			SINK_OPEN:  take = 1'b1;
			SINK_COIN:  take = 1'($urandom_range(0, 1));
			SINK_LIGHT: take = ($urandom_range(0, 6) != 0);
			default:    take = ((tick % period) == 0);
		endcase
		rsp_ch.ready <= take;
	end

	// Watchdog
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule
